[src/cgm_pkg.sv]
// ----------------------------------------------------------------------------
// cgm_pkg
// Shared widths, register codes, reset values and types of the colour
// gradient map.
// ----------------------------------------------------------------------------
package cgm_pkg;

    // field widths
    localparam int CH_W       = 8;
    localparam int POS_W      = 8;
    localparam int NUM_STOPS  = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int PAIR_W     = 2 * RGB_W;
    localparam int POSVEC_W   = NUM_STOPS * POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POSVEC_W;

    // interpolation datapath widths
    localparam int PROD_W   = 2 * CH_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int DEN_W    = CH_W + 1;
    // multiply stage, numerator stage, then one stage per quotient bit
    localparam int LERP_LAT = 2 + CH_W;

    localparam int SEGMENTS_DEF = 7;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_POS = 3'd0,
        REG_COLORS_0 = 3'd1,
        REG_COLORS_1 = 3'd2,
        REG_COLORS_2 = 3'd3,
        REG_COLORS_3 = 3'd4
    } cfg_reg_t;

    // reset values
    localparam logic [POSVEC_W-1:0] STOP_POS_RST = 64'hFFFF_FFFF_C060_2000;
    localparam logic [PAIR_W-1:0]   COLORS_0_RST = 48'h0000_C000_0060;
    localparam logic [PAIR_W-1:0]   COLORS_1_RST = 48'hC080_8000_C000;
    localparam logic [PAIR_W-1:0]   COLORS_2_RST = 48'h0000_00FF_FFFF;
    localparam logic [PAIR_W-1:0]   COLORS_3_RST = 48'h0000_0000_0000;

    typedef logic [NUM_STOPS-1:0][RGB_W-1:0] stops_t;

    // control that travels alongside each beat
    typedef struct packed {
        logic valid;
        logic covered;
    } ctrl_t;

endpackage

[src/cgm_seg_sel.sv]
// ----------------------------------------------------------------------------
// cgm_seg_sel
// Finds the highest covering segment for a height and registers its end
// colours, offset into the segment and segment length.
// ----------------------------------------------------------------------------
module cgm_seg_sel
    import cgm_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [POS_W-1:0]    height,
    input  logic [POSVEC_W-1:0] positions,
    input  stops_t              stops,
    output ctrl_t               ctrl,
    output logic [CH_W-1:0]     offset,
    output logic [CH_W-1:0]     steps,
    output logic [RGB_W-1:0]    rgb_a,
    output logic [RGB_W-1:0]    rgb_b
);

    logic [POS_W-1:0] seg_first;
    logic [POS_W-1:0] seg_last;
    logic [POS_W-1:0] sel_first;
    logic [POS_W-1:0] sel_last;
    logic             hit;
    logic [RGB_W-1:0] sel_a;
    logic [RGB_W-1:0] sel_b;

    ctrl_t            ctrl_reg;
    ctrl_t            ctrl_next;
    logic [CH_W-1:0]  offset_reg;
    logic [CH_W-1:0]  offset_next;
    logic [CH_W-1:0]  steps_reg;
    logic [CH_W-1:0]  steps_next;
    logic [RGB_W-1:0] rgb_a_reg;
    logic [RGB_W-1:0] rgb_b_reg;

    // priority search, later segments override earlier ones
    always_comb
    begin
        hit       = 1'b0;
        sel_first = '0;
        sel_last  = '0;
        sel_a     = '0;
        sel_b     = '0;
        seg_first = '0;
        seg_last  = '0;
        for (int s = 0; s < SEGMENTS; s++)
        begin
            seg_first = positions[s*POS_W +: POS_W];
            seg_last  = positions[(s+1)*POS_W +: POS_W];
            if (seg_first < seg_last && seg_first <= height && height <= seg_last)
            begin
                hit       = 1'b1;
                sel_first = seg_first;
                sel_last  = seg_last;
                sel_a     = stops[s];
                sel_b     = stops[s+1];
            end
        end
    end

    // next values of the stage registers
    always_comb
    begin
        ctrl_next.valid   = in_valid;
        ctrl_next.covered = hit;
        offset_next       = height - sel_first;
        steps_next        = sel_last - sel_first;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        steps_reg  <= steps_next;
        rgb_a_reg  <= sel_a;
        rgb_b_reg  <= sel_b;
    end

    assign ctrl   = ctrl_reg;
    assign offset = offset_reg;
    assign steps  = steps_reg;
    assign rgb_a  = rgb_a_reg;
    assign rgb_b  = rgb_b_reg;

endmodule

[src/cgm_lerp.sv]
// ----------------------------------------------------------------------------
// cgm_lerp
// One colour channel: (a*(steps-offset) + b*offset) / steps rounded half up,
// as a multiply stage, a numerator stage and a pipelined restoring divider
// that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module cgm_lerp
    import cgm_pkg::*;
(
    input  logic            clk,
    input  logic [CH_W-1:0] a,
    input  logic [CH_W-1:0] b,
    input  logic [CH_W-1:0] offset,
    input  logic [CH_W-1:0] steps,
    output logic [CH_W-1:0] q
);

    logic [CH_W-1:0]   rest;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_a_next;
    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] prod_b_next;
    logic [CH_W-1:0]   steps_m_reg;
    logic [PROD_W-1:0] prod_sum;

    logic [NUM_W-1:0]  rem_reg  [0:CH_W-1];
    logic [NUM_W-1:0]  rem_next [0:CH_W-1];
    logic [DEN_W-1:0]  den_reg  [0:CH_W-1];
    logic [DEN_W-1:0]  den_next [0:CH_W-1];
    logic [NUM_W-1:0]  trial    [0:CH_W-1];
    logic              fit      [0:CH_W-1];
    logic [CH_W-1:0]   quo_prev [0:CH_W-1];
    logic [CH_W-1:0]   quo_reg  [1:CH_W];
    logic [CH_W-1:0]   quo_next [1:CH_W];

    // weights of the two end colours
    always_comb
    begin
        rest        = steps - offset;
        prod_a_next = PROD_W'(a) * PROD_W'(rest);
        prod_b_next = PROD_W'(b) * PROD_W'(offset);
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        steps_m_reg <= steps;
    end

    // rounded quotient is (2*num + steps) / (2*steps)
    always_comb
    begin
        prod_sum    = prod_a_reg + prod_b_reg;
        rem_next[0] = {prod_sum, 1'b0} + NUM_W'(steps_m_reg);
        den_next[0] = {steps_m_reg, 1'b0};
    end

    // divider stages, most significant quotient bit first
    for (genvar k = 0; k < CH_W; k++)
    begin : g_div
        localparam int SH = CH_W - 1 - k;

        if (k == 0)
        begin : g_first
            assign quo_prev[k] = '0;
        end
        else
        begin : g_rest
            assign quo_prev[k] = quo_reg[k];
        end

        assign trial[k]      = NUM_W'(den_reg[k]) << SH;
        assign fit[k]        = (rem_reg[k] >= trial[k]);
        assign quo_next[k+1] = {quo_prev[k][CH_W-2:0], fit[k]};

        if (k < CH_W - 1)
        begin : g_carry
            assign rem_next[k+1] = fit[k] ? (rem_reg[k] - trial[k]) : rem_reg[k];
            assign den_next[k+1] = den_reg[k];
        end
    end

    // divider registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CH_W; i++)
        begin
            rem_reg[i]   <= rem_next[i];
            den_reg[i]   <= den_next[i];
            quo_reg[i+1] <= quo_next[i+1];
        end
    end

    assign q = quo_reg[CH_W];

endmodule

[src/color_gradient_map_core.sv]
// ----------------------------------------------------------------------------
// color_gradient_map_core
// Piecewise-linear colour gradient: maps a height to an RGB colour through
// configurable stop positions and stop colours.
// ----------------------------------------------------------------------------
// done follows the segment-select register, the interpolator stages and the output register
// throughput: one height per clock, start may stay high; busy is always low
// the depth comes from the 8-stage bit-per-stage divider of each channel
// results cannot be held off: each beat shows for one cycle under done
// reset clears the pipeline valid bits and loads the default gradient
// ----------------------------------------------------------------------------
module color_gradient_map_core
    import cgm_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [POS_W-1:0]      height,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic                  done,
    output logic [CH_W-1:0]       red,
    output logic [CH_W-1:0]       green,
    output logic [CH_W-1:0]       blue,
    output logic                  covered
);

    logic [POSVEC_W-1:0] stop_pos_reg;
    logic [PAIR_W-1:0]   colors_reg [0:3];
    stops_t              stops;

    ctrl_t               sel_ctrl;
    logic [CH_W-1:0]     sel_offset;
    logic [CH_W-1:0]     sel_steps;
    logic [RGB_W-1:0]    sel_rgb_a;
    logic [RGB_W-1:0]    sel_rgb_b;

    ctrl_t               ctrl_pipe_reg [0:LERP_LAT-1];
    logic [CH_W-1:0]     chan_q [0:2];

    logic                done_reg;
    logic                done_next;
    logic                covered_reg;
    logic                covered_next;
    logic [CH_W-1:0]     rgb_reg  [0:2];
    logic [CH_W-1:0]     rgb_next [0:2];

    logic                accept;

    // the pipeline never stalls, so a start beat is always taken
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_pos_reg  <= STOP_POS_RST;
            colors_reg[0] <= COLORS_0_RST;
            colors_reg[1] <= COLORS_1_RST;
            colors_reg[2] <= COLORS_2_RST;
            colors_reg[3] <= COLORS_3_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STOP_POS: stop_pos_reg  <= wr_data;
                REG_COLORS_0: colors_reg[0] <= wr_data[PAIR_W-1:0];
                REG_COLORS_1: colors_reg[1] <= wr_data[PAIR_W-1:0];
                REG_COLORS_2: colors_reg[2] <= wr_data[PAIR_W-1:0];
                REG_COLORS_3: colors_reg[3] <= wr_data[PAIR_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the stop colours, two per pair register
    always_comb
    begin
        for (int k = 0; k < NUM_STOPS; k++)
            stops[k] = colors_reg[k/2][(k%2)*RGB_W +: RGB_W];
    end

    // segment search
    cgm_seg_sel #(
        .SEGMENTS (SEGMENTS)
    ) u_seg_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .height    (height),
        .positions (stop_pos_reg),
        .stops     (stops),
        .ctrl      (sel_ctrl),
        .offset    (sel_offset),
        .steps     (sel_steps),
        .rgb_a     (sel_rgb_a),
        .rgb_b     (sel_rgb_b)
    );

    // one interpolator per channel, red first
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        cgm_lerp u_lerp (
            .clk    (clk),
            .a      (sel_rgb_a[RGB_W-1-c*CH_W -: CH_W]),
            .b      (sel_rgb_b[RGB_W-1-c*CH_W -: CH_W]),
            .offset (sel_offset),
            .steps  (sel_steps),
            .q      (chan_q[c])
        );
    end

    // control travels beside the interpolators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LERP_LAT; i++)
                ctrl_pipe_reg[i] <= '0;
        end
        else
        begin
            ctrl_pipe_reg[0] <= sel_ctrl;
            for (int i = 1; i < LERP_LAT; i++)
                ctrl_pipe_reg[i] <= ctrl_pipe_reg[i-1];
        end
    end

    // output beat, black when no segment covers the height
    always_comb
    begin
        done_next    = ctrl_pipe_reg[LERP_LAT-1].valid;
        covered_next = ctrl_pipe_reg[LERP_LAT-1].covered;
        for (int c = 0; c < 3; c++)
            rgb_next[c] = covered_next ? chan_q[c] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            covered_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= done_next;
            covered_reg <= covered_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            rgb_reg[c] <= rgb_next[c];
    end

    assign done    = done_reg;
    assign covered = covered_reg;
    assign red     = rgb_reg[0];
    assign green   = rgb_reg[1];
    assign blue    = rgb_reg[2];

endmodule
